@@ rtl/open_addressed_hash_table_unit_defines.svh @@
// Assertion macros shared by the hash table RTL.
`ifndef OPEN_ADDRESSED_HASH_TABLE_UNIT_DEFINES_SVH
`define OPEN_ADDRESSED_HASH_TABLE_UNIT_DEFINES_SVH

// Check a condition at every clock edge out of reset.
`define OAHT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define OAHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/oaht_pkg.sv @@
// Types, codes and constants for the open-addressed hash table unit.
package oaht_pkg;

  localparam int CAP_LOG2_DEF   = 10;
  localparam int KEY_WIDTH_DEF  = 64;

  localparam int KIND_W   = 2;
  localparam int KEY_IN_W = 64;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 10;
  localparam int LIVE_W   = 11;
  localparam int LIMIT_W  = 11;

  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 88;

  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = 11'd512;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_ZERO_KEY = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_CHECK,
    ST_EMIT
  } oaht_state_t;

endpackage

@@ rtl/oaht_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/open_addressed_hash_table_unit.sv @@
// Open-addressed key/value table with quadratic probing: top level.
//
// Usage notes. The table holds 2**CAPACITY_LOG2 slots of a KEY_WIDTH-bit key,
// a tombstone flag and a 64-bit value. Each item (insert, lookup or remove,
// given by in_tuser) yields exactly one result item. After reset the key
// store is swept to empty, one slot a cycle, so the block holds in_tready low
// until every slot is cleared; cfg writes are taken throughout. The block
// works on one item at a time. An item whose key is zero, whose kind is
// unused, or an insert refused by the load limit, goes from idle straight
// to emit. Any other item probes P slots (at most 2**CAPACITY_LOG2): each
// probe is one read of the key store, registered, then one compare and one
// shared adder step that advances the slot index by n squared; the item
// then waits in emit for the output register and returns to idle. Probes
// go one at a time through the single read port on the key store. A
// finished result waits in the output register while the next item is
// accepted. load_limit (cfg_wdata) is the used-slot count at which inserts
// are refused as full; it resets to 512 and must be written only while the
// block is idle.
`include "open_addressed_hash_table_unit_defines.svh"

module open_addressed_hash_table_unit #(
  parameter int CAPACITY_LOG2 = oaht_pkg::CAP_LOG2_DEF,
  parameter int KEY_WIDTH     = oaht_pkg::KEY_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration: load_limit
  input  logic                              cfg_we,
  input  logic [oaht_pkg::LIMIT_W-1:0]      cfg_wdata,
  // input items
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [oaht_pkg::IN_TDATA_W-1:0]   in_tdata,   // key[63:0], value[127:64]
  input  logic [oaht_pkg::KIND_W-1:0]       in_tuser,   // kind[1:0]
  // result items
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [oaht_pkg::OUT_TDATA_W-1:0]  out_tdata,  // value_out[63:0], slot[73:64],
                                                        // live_count[84:74], zero pad
  output logic [oaht_pkg::STATUS_W-1:0]     out_tuser   // status[1:0]
);

  import oaht_pkg::*;

  localparam int          IW         = CAPACITY_LOG2;
  localparam int          CW         = CAPACITY_LOG2 + 1;
  localparam int unsigned CAPACITY   = 2 ** CAPACITY_LOG2;
  localparam int          SLOT_EXT_W = (IW > SLOT_W) ? IW : SLOT_W;
  localparam int          CNT_EXT_W  = (CW > LIVE_W) ? CW : LIVE_W;
  localparam logic [CW-1:0] N_LAST   = CW'(CAPACITY);
  localparam logic [IW-1:0] IDX_LAST = IW'(CAPACITY - 1);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  oaht_state_t state_r, state_nxt;

  logic [KIND_W-1:0]    kind_r,  kind_nxt;
  logic [KEY_WIDTH-1:0] key_r,   key_nxt;
  logic [VALUE_W-1:0]   value_r, value_nxt;

  // probe position, probe number and n squared modulo the table size
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] sq_r,  sq_nxt;
  logic [CW-1:0] n_r,   n_nxt;
  logic [IW-1:0] clr_idx_r, clr_idx_nxt;

  logic [CW-1:0]      used_r, used_nxt;
  logic [CW-1:0]      live_r, live_nxt;
  logic [LIMIT_W-1:0] limit_r;

  // pending result, waiting for the output register
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [VALUE_W-1:0]  res_value_r,  res_value_nxt;
  logic [IW-1:0]       res_slot_r,   res_slot_nxt;

  logic                out_valid_r,  out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]  out_value_r,  out_value_nxt;
  logic [SLOT_W-1:0]   out_slot_r,   out_slot_nxt;
  logic [LIVE_W-1:0]   out_live_r,   out_live_nxt;

  // ---------------------------------------------------------------------------
  // Stores: key store carries the tombstone flag in its top bit
  // ---------------------------------------------------------------------------
  logic                 key_we;
  logic [IW-1:0]        key_waddr;
  logic [KEY_WIDTH:0]   key_wdata;
  logic [KEY_WIDTH:0]   key_rdata;
  logic                 val_we;
  logic [VALUE_W-1:0]   val_rdata;

  oaht_ram #(
    .WIDTH (KEY_WIDTH + 1),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (idx_r),
    .rdata (key_rdata)
  );

  oaht_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (idx_r),
    .wdata (value_r),
    .raddr (idx_r),
    .rdata (val_rdata)
  );

  // ---------------------------------------------------------------------------
  // Decode of an incoming item
  // ---------------------------------------------------------------------------
  logic [KEY_IN_W-1:0]  in_key;
  logic [KEY_WIDTH-1:0] in_key_m;
  logic                 accept;
  logic                 acc_zero;
  logic                 acc_bad_kind;
  logic                 acc_full;
  logic                 acc_probe;

  assign in_key       = in_tdata[KEY_IN_W-1:0];
  assign in_key_m     = in_key[KEY_WIDTH-1:0];
  assign accept       = in_tvalid && in_tready;
  assign acc_zero     = (in_key_m == '0);
  assign acc_bad_kind = !(in_tuser inside {KIND_INSERT, KIND_LOOKUP, KIND_REMOVE});
  assign acc_full     = (in_tuser == KIND_INSERT)
                        && (CNT_EXT_W'(used_r) >= CNT_EXT_W'(limit_r));
  assign acc_probe    = !acc_zero && !acc_bad_kind && !acc_full;

  // ---------------------------------------------------------------------------
  // Decode of one probed slot
  // ---------------------------------------------------------------------------
  logic          is_ins;
  logic          is_rem;
  logic          hit_empty;
  logic          hit_key;
  logic          rd_tomb;
  logic          ins_take;
  logic          found;
  logic          probe_last;
  logic          chk_done;
  logic          out_free;
  logic [IW:0]   twice_n_p1;

  assign is_ins     = (kind_r == KIND_INSERT);
  assign is_rem     = (kind_r == KIND_REMOVE);
  assign hit_empty  = (key_rdata[KEY_WIDTH-1:0] == '0);
  assign hit_key    = (key_rdata[KEY_WIDTH-1:0] == key_r);
  assign rd_tomb    = key_rdata[KEY_WIDTH];
  assign ins_take   = hit_empty || (hit_key && rd_tomb);
  assign found      = hit_key && !rd_tomb;
  assign probe_last = (n_r == N_LAST);
  assign chk_done   = is_ins ? (ins_take || probe_last)
                             : (hit_empty || hit_key || probe_last);
  assign out_free   = !out_valid_r || out_tready;
  assign twice_n_p1 = {n_r[IW-1:0], 1'b1};

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_idx_r == IDX_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = acc_probe ? ST_PROBE : ST_EMIT;
      end
      ST_PROBE: state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = chk_done ? ST_EMIT : ST_PROBE;
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: control outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_tready = 1'b0;
    key_we    = 1'b0;
    key_waddr = idx_r;
    key_wdata = {1'b0, key_r};
    val_we    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        // sweep the key store to empty, tombstones cleared
        key_we    = 1'b1;
        key_waddr = clr_idx_r;
        key_wdata = '0;
      end
      ST_IDLE: in_tready = 1'b1;
      ST_CHECK: begin
        if (is_ins && ins_take) begin
          key_we = 1'b1;
          val_we = 1'b1;
        end else if (is_rem && found) begin
          key_we    = 1'b1;
          key_wdata = {1'b1, key_r};
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath next values
  // ---------------------------------------------------------------------------
  logic [SLOT_EXT_W-1:0] slot_ext;
  logic [CNT_EXT_W-1:0]  live_ext;

  assign slot_ext = SLOT_EXT_W'(res_slot_r);
  assign live_ext = CNT_EXT_W'(live_r);

  always_comb begin
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    value_nxt      = value_r;
    idx_nxt        = idx_r;
    sq_nxt         = sq_r;
    n_nxt          = n_r;
    clr_idx_nxt    = clr_idx_r;
    used_nxt       = used_r;
    live_nxt       = live_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_slot_nxt   = out_slot_r;
    out_live_nxt   = out_live_r;

    // drop a result the moment it is taken
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_CLEAR: clr_idx_nxt = clr_idx_r + 1'b1;
      ST_IDLE: begin
        if (accept) begin
          kind_nxt      = in_tuser;
          key_nxt       = in_key_m;
          value_nxt     = in_tdata[IN_TDATA_W-1:KEY_IN_W];
          idx_nxt       = IW'(in_key_m);
          sq_nxt        = IW'(1);
          n_nxt         = CW'(1);
          res_value_nxt = '0;
          res_slot_nxt  = '0;
          if (acc_zero)          res_status_nxt = STAT_ZERO_KEY;
          else if (acc_bad_kind) res_status_nxt = STAT_NOTFOUND;
          else if (acc_full)     res_status_nxt = STAT_FULL;
          else                   res_status_nxt = STAT_OK;
        end
      end
      ST_CHECK: begin
        if (is_ins) begin
          if (ins_take) begin
            res_status_nxt = STAT_OK;
            res_slot_nxt   = idx_r;
            live_nxt       = live_r + 1'b1;
            if (hit_empty) used_nxt = used_r + 1'b1;
          end else if (probe_last) begin
            res_status_nxt = STAT_FULL;
          end
        end else if (found) begin
          res_status_nxt = STAT_OK;
          res_slot_nxt   = idx_r;
          if (is_rem) begin
            if (live_r != '0) live_nxt = live_r - 1'b1;
          end else begin
            res_value_nxt = val_rdata;
          end
        end else if (hit_empty || hit_key || probe_last) begin
          res_status_nxt = STAT_NOTFOUND;
        end
        // shared adder step: advance by n squared, then n squared to (n+1) squared
        if (!chk_done) begin
          idx_nxt = idx_r + sq_r;
          sq_nxt  = sq_r + twice_n_p1[IW-1:0];
          n_nxt   = n_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_slot_nxt   = slot_ext[SLOT_W-1:0];
          out_live_nxt   = live_ext[LIVE_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      used_r      <= '0;
      live_r      <= '0;
      limit_r     <= LOAD_LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      used_r      <= used_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    value_r      <= value_nxt;
    idx_r        <= idx_nxt;
    sq_r         <= sq_nxt;
    n_r          <= n_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_slot_r   <= out_slot_nxt;
    out_live_r   <= out_live_nxt;
  end

  // ---------------------------------------------------------------------------
  // Result port
  // ---------------------------------------------------------------------------
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {(OUT_TDATA_W - VALUE_W - SLOT_W - LIVE_W)'(0),
                       out_live_r, out_slot_r, out_value_r};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `OAHT_ASSERT_ALWAYS(a_live_le_used, live_r <= used_r, "live entries exceed used slots")
  `OAHT_ASSERT_ALWAYS(a_used_le_cap, used_r <= N_LAST, "used slots exceed table size")
  `OAHT_ASSERT_ALWAYS(a_key_write_state,
    !key_we || state_r == ST_CLEAR || state_r == ST_CHECK, "key store written out of turn")
  `OAHT_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready,
    "second item accepted back to back")

endmodule

@@ test/tb_open_addressed_hash_table_unit.sv @@
// Self-checking testbench for the open-addressed hash table unit, with its own table model.
`timescale 1ns / 1ps

module tb_open_addressed_hash_table_unit;
  import oaht_pkg::*;

  localparam int TABLE_SLOTS = 1 << CAP_LOG2_DEF;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES = 16;
  // kind 3 is not an operation: unless the key is zero the block answers not found; it changes nothing
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value_out;
    logic [SLOT_W-1:0]   slot;
    logic [LIVE_W-1:0]   live;
  } table_reply_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [LIMIT_W-1:0]     cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [KIND_W-1:0]      in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;

  // Model of the table: keys, values, tombstones and the two counters.
  bit [KEY_IN_W-1:0] slot_key [TABLE_SLOTS];
  bit [VALUE_W-1:0]  slot_val [TABLE_SLOTS];
  bit                slot_tomb [TABLE_SLOTS];
  int unsigned       used_slots = 0;
  int unsigned       live_keys = 0;
  logic [LIMIT_W-1:0] limit_reg = LOAD_LIMIT_RESET;

  table_reply_t      owed_replies [$];
  logic [KEY_IN_W-1:0] key_pool [$];

  int          failures = 0;
  int          replies_checked = 0;
  int          status_count [4] = '{default: 0};
  bit          idle_on = 1'b1;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  always #2 clk = ~clk;

  open_addressed_hash_table_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // key[63:0], value[127:64]
    .in_tuser   (in_tuser),    // kind[1:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // value_out[63:0], slot[73:64], live_count[84:74], zero pad
    .out_tuser  (out_tuser)    // status[1:0]
  );

  // Walk the probe chain of a key; stop at an empty slot or at the key itself.
  // A tombstoned copy of the key ends the search as a miss.
  function automatic bit find_live_slot(input logic [KEY_IN_W-1:0] key,
                                        output int unsigned at);
    int unsigned idx;
    int unsigned n;
    idx = key[SLOT_W-1:0];
    at = 0;
    for (n = 1; n <= TABLE_SLOTS; n++) begin
      if (slot_key[idx] == '0) return 1'b0;
      if (slot_key[idx] == key) begin
        if (slot_tomb[idx]) return 1'b0;
        at = idx;
        return 1'b1;
      end
      idx = (idx + n * n) % TABLE_SLOTS;
    end
    return 1'b0;
  endfunction

  // Apply one operation to the model table and work out the reply it owes.
  function automatic void apply_table_op(input logic [KIND_W-1:0] kind,
                                         input logic [KEY_IN_W-1:0] key,
                                         input logic [VALUE_W-1:0] value,
                                         output table_reply_t r);
    int unsigned idx;
    int unsigned n;
    int unsigned at;
    bit done;
    r.status = STAT_NOTFOUND;
    r.value_out = '0;
    r.slot = '0;
    if (key == '0) begin
      r.status = STAT_ZERO_KEY;
    end else if (kind == KIND_INSERT) begin
      r.status = STAT_FULL;
      if (used_slots < limit_reg) begin
        idx = key[SLOT_W-1:0];
        done = 1'b0;
        // take the first empty slot, or the key's own tombstone; a live copy is passed by
        for (n = 1; n <= TABLE_SLOTS && !done; n++) begin
          if (slot_key[idx] == '0 || (slot_key[idx] == key && slot_tomb[idx])) begin
            if (slot_key[idx] == '0) used_slots++;
            slot_key[idx] = key;
            slot_val[idx] = value;
            slot_tomb[idx] = 1'b0;
            live_keys++;
            r.status = STAT_OK;
            r.slot = idx[SLOT_W-1:0];
            done = 1'b1;
          end else begin
            idx = (idx + n * n) % TABLE_SLOTS;
          end
        end
      end
    end else if (kind == KIND_LOOKUP || kind == KIND_REMOVE) begin
      if (find_live_slot(key, at)) begin
        r.status = STAT_OK;
        r.slot = at[SLOT_W-1:0];
        if (kind == KIND_LOOKUP) begin
          r.value_out = slot_val[at];
        end else begin
          slot_tomb[at] = 1'b1;
          if (live_keys > 0) live_keys--;
        end
      end
    end
    r.live = live_keys[LIVE_W-1:0];
  endfunction

  // Predict the reply, then offer the item, with an occasional idle burst ahead of it.
  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [KEY_IN_W-1:0] key,
                         input logic [VALUE_W-1:0] value);
    table_reply_t r;
    int gap;
    apply_table_op(kind, key, value, r);
    owed_replies.push_back(r);
    if (kind == KIND_INSERT && key != '0) begin
      key_pool.push_back(key);
      if (key_pool.size() > 48) void'(key_pool.pop_front());
    end
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {value, key};
    in_tuser <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid and hold off until every owed reply has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] limit);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= limit;
    limit_reg = limit;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random operation: nearly half keys already seen, so hits, duplicates and tombstones occur;
  // some share a home slot with a known key, some are corner keys, a few are zero.
  function automatic void pick_random_op(output logic [KIND_W-1:0] kind,
                                         output logic [KEY_IN_W-1:0] key,
                                         output logic [VALUE_W-1:0] value);
    int roll;
    logic [KEY_IN_W-1:0] near;
    roll = $urandom_range(0, 99);
    if (roll < 40) kind = KIND_INSERT;
    else if (roll < 72) kind = KIND_LOOKUP;
    else if (roll < 95) kind = KIND_REMOVE;
    else kind = KIND_UNUSED;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      key = '0;
    end else if (roll < 50 && key_pool.size() != 0) begin
      key = key_pool[$urandom_range(0, key_pool.size() - 1)];
    end else if (roll < 62 && key_pool.size() != 0) begin
      near = key_pool[$urandom_range(0, key_pool.size() - 1)];
      key = {$urandom, $urandom};
      key[SLOT_W-1:0] = near[SLOT_W-1:0];
    end else if (roll < 66) begin
      case ($urandom_range(0, 3))
        0: key = '1;
        1: key = 64'd1;
        2: key = {1'b1, 63'd0};
        default: key = 64'd1024;
      endcase
    end else begin
      key = {$urandom, $urandom};
    end
    roll = $urandom_range(0, 19);
    if (roll == 0) value = '0;
    else if (roll == 1) value = '1;
    else value = {$urandom, $urandom};
  endfunction

  // Extremes, every kind, zero keys, duplicates, tombstones and both kinds of refusal.
  task automatic test_directed();
    send_op(KIND_LOOKUP, 64'd1, '0);                 // empty table: miss
    send_op(KIND_INSERT, '0, '1);                    // zero key on every kind
    send_op(KIND_LOOKUP, '0, '0);
    send_op(KIND_REMOVE, '0, '0);
    send_op(KIND_UNUSED, '0, '0);
    send_op(KIND_UNUSED, 64'd5, '1);                 // unused kind changes nothing
    send_op(KIND_INSERT, '1, '1);
    send_op(KIND_INSERT, 64'd1, '0);
    send_op(KIND_INSERT, 64'd1, 64'h0123_4567_89ab_cdef);  // stored twice
    send_op(KIND_LOOKUP, '1, '0);
    send_op(KIND_REMOVE, 64'd1, '0);                 // tombstones the first copy
    send_op(KIND_LOOKUP, 64'd1, '0);                 // stops at its own tombstone
    send_op(KIND_REMOVE, 64'd1, '0);
    send_op(KIND_INSERT, 64'd1, 64'hfedc_ba98_7654_3210);  // reuses the tombstone
    send_op(KIND_LOOKUP, 64'd1, '0);
    send_op(KIND_INSERT, 64'd1025, 64'h5555_aaaa_5555_aaaa);  // same home as key 1
    send_op(KIND_LOOKUP, 64'd1025, '0);
    send_op(KIND_REMOVE, {1'b1, 63'd0}, '0);
    wait_drained();
    // limit at the used count: even a tombstone of the same key is refused
    write_limit(used_slots[LIMIT_W-1:0]);
    send_op(KIND_INSERT, 64'h0000_0001_0000_0007, '1);
    send_op(KIND_REMOVE, 64'd1, '0);
    send_op(KIND_INSERT, 64'd1, '0);
    wait_drained();
    write_limit(11'd1);
    send_op(KIND_INSERT, 64'd99, '1);
    send_op(KIND_LOOKUP, 64'd1025, '0);
    wait_drained();
  endtask

  task automatic test_random_mix(input int items, input int limit);
    logic [KIND_W-1:0]   kind;
    logic [KEY_IN_W-1:0] key;
    logic [VALUE_W-1:0]  value;
    wait_drained();
    write_limit(limit[LIMIT_W-1:0]);
    repeat (items) begin
      pick_random_op(kind, key, value);
      send_op(kind, key, value);
    end
  endtask

  // Receiver holds off for a long stretch while items keep coming: the block fills and
  // stalls its input until the receiver lets go.
  task automatic test_backpressure();
    logic [KIND_W-1:0]   kind;
    logic [KEY_IN_W-1:0] key;
    logic [VALUE_W-1:0]  value;
    wait_drained();
    write_limit(LIMIT_W'(TABLE_SLOTS));
    @(posedge clk);
    hold_left = HOLD_OFF_CYCLES;
    repeat (200) begin
      pick_random_op(kind, key, value);
      send_op(kind, key, value);
    end
  endtask

  // Occupy every slot on one probe chain with keys sitting at their home slots, then
  // send a fresh key down that chain: insert runs out of probes, lookup and remove
  // give up after a full table of probes. Runs without idling.
  task automatic test_probe_exhaustion();
    bit on_chain [TABLE_SLOTS];
    int unsigned home;
    int unsigned idx;
    int unsigned n;
    logic [KEY_IN_W-1:0] key;
    logic [KEY_IN_W-1:0] last_fill;
    idle_on = 1'b0;
    wait_drained();
    write_limit(LIMIT_W'(TABLE_SLOTS));
    home = $urandom_range(0, TABLE_SLOTS - 1);
    idx = home;
    for (n = 1; n <= TABLE_SLOTS; n++) begin
      on_chain[idx] = 1'b1;
      idx = (idx + n * n) % TABLE_SLOTS;
    end
    last_fill = '1;
    for (idx = 0; idx < TABLE_SLOTS; idx++) begin
      if (on_chain[idx] && slot_key[idx] == '0) begin
        key = {$urandom, $urandom};
        key[KEY_IN_W-1] = 1'b1;
        key[SLOT_W-1:0] = idx[SLOT_W-1:0];
        last_fill = key;
        send_op(KIND_INSERT, key, {$urandom, $urandom});
      end
    end
    key = {$urandom, $urandom};
    key[KEY_IN_W-1] = 1'b1;
    key[SLOT_W-1:0] = home[SLOT_W-1:0];
    send_op(KIND_INSERT, key, '1);
    send_op(KIND_LOOKUP, key, '0);
    send_op(KIND_REMOVE, key, '0);
    send_op(KIND_LOOKUP, last_fill, '0);
    wait_drained();
  endtask

  // Receiver: long hold-off first, then random stall bursts, else ready.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 14);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each accepted reply with the oldest one owed, field by field.
  always @(posedge clk) begin : check_replies
    table_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_replies.size() == 0) begin
        $error("reply with none owed: tuser %h tdata %h", out_tuser, out_tdata);
        failures++;
      end else begin
        want = owed_replies.pop_front();
        replies_checked++;
        status_count[want.status]++;
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          failures++;
        end
        if (out_tdata[VALUE_W-1:0] !== want.value_out) begin
          $error("value_out: expected %h, got %h", want.value_out, out_tdata[VALUE_W-1:0]);
          failures++;
        end
        if (out_tdata[VALUE_W +: SLOT_W] !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_tdata[VALUE_W +: SLOT_W]);
          failures++;
        end
        if (out_tdata[VALUE_W + SLOT_W +: LIVE_W] !== want.live) begin
          $error("live_count: expected %0d, got %0d", want.live,
                 out_tdata[VALUE_W + SLOT_W +: LIVE_W]);
          failures++;
        end
      end
    end
  end

  initial begin : watchdog
    #100ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_mix(450, TABLE_SLOTS);
    test_random_mix(350, $urandom_range(1, TABLE_SLOTS));
    test_backpressure();
    test_random_mix(300, used_slots + 16);
    test_probe_exhaustion();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d replies: %0d done/found, %0d not found, %0d full, %0d zero key",
             replies_checked, status_count[STAT_OK], status_count[STAT_NOTFOUND],
             status_count[STAT_FULL], status_count[STAT_ZERO_KEY]);
    $display("Load limits 1 to %0d, duplicates, tombstones, %0d-cycle hold-off, full probe chain",
             TABLE_SLOTS, HOLD_OFF_CYCLES);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
